[sv/fwr_pkg.sv]
// Package with shared types and constants for the first-word replace stream.
`default_nettype none
package fwr_pkg;

  // Register indexes of the configuration port
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEARCH_WORD    = 2'd0,
    CFG_SEARCH_LENGTH  = 2'd1,
    CFG_REPLACE_WORD   = 2'd2,
    CFG_REPLACE_LENGTH = 2'd3
  } cfg_idx_e;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned LEN_W      = 4;
  localparam logic [LEN_W-1:0] WORD_BYTES = 4'd8;
  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } fsm_state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // input transfer this cycle
    logic load;    // load next burst byte into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic burst_nonempty;  // accepted item produces at least one byte
    logic emit_last;       // byte being loaded is the last of its burst
    logic out_busy;        // output register holds a byte that is not taken
  } dpath_sts_t;

endpackage
`default_nettype wire

[sv/fwr_ctrl.sv]
// Controller: accepts input bytes and sequences the output bursts.
`default_nettype none
module fwr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire fwr_pkg::dpath_sts_t sts_i,
  output fwr_pkg::ctrl_cmd_t      cmd_o
);

  fwr_pkg::fsm_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fwr_pkg::ST_IDLE: begin
        if (in_valid_i && sts_i.burst_nonempty) begin
          state_d = fwr_pkg::ST_EMIT;
        end
      end
      fwr_pkg::ST_EMIT: begin
        if (!sts_i.out_busy && sts_i.emit_last) begin
          state_d = fwr_pkg::ST_IDLE;
        end
      end
      default: state_d = fwr_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      fwr_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      fwr_pkg::ST_EMIT: begin
        cmd_o.load = !sts_i.out_busy;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fwr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[sv/fwr_dpath.sv]
// Datapath: configuration, word buffer, match tracking, burst and output registers.
`default_nettype none
module fwr_dpath #(
  parameter int unsigned MAX_WORD = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write
  input  wire logic                            cfg_valid_i,
  input  wire logic [fwr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [fwr_pkg::WORD_W-1:0]      cfg_data_i,
  // input item
  input  wire logic [fwr_pkg::BYTE_W-1:0]      char_i,
  input  wire logic                            eom_i,
  // output register
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output logic [fwr_pkg::BYTE_W-1:0]           out_char_o,
  output logic                                 out_last_msg_o,
  output logic                                 out_last_burst_o,
  // controller link
  input  wire fwr_pkg::ctrl_cmd_t              cmd_i,
  output fwr_pkg::dpath_sts_t                  sts_o
);

  localparam int unsigned IdxW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam logic [fwr_pkg::LEN_W-1:0] MaxLen = fwr_pkg::LEN_W'(MAX_WORD);

  // configuration registers
  logic [fwr_pkg::WORD_W-1:0] search_word_q, replace_word_q;
  logic [fwr_pkg::LEN_W-1:0]  search_len_q, replace_len_q;

  // word state
  logic [fwr_pkg::BYTE_W-1:0] word_buf_q [MAX_WORD];
  logic [fwr_pkg::LEN_W-1:0]  len_q, len_d;
  logic                       ovf_q, ovf_d;
  logic                       rdone_q, rdone_d;
  logic                       eq_q, eq_d;    // buffered bytes equal the search prefix

  // burst registers
  logic                       src_repl_q, src_repl_d;
  logic [fwr_pkg::LEN_W-1:0]  cnt_q, cnt_d;
  logic [fwr_pkg::LEN_W-1:0]  total_q, total_d;
  logic [fwr_pkg::LEN_W-1:0]  idx_q;
  logic                       extra_d;
  logic [fwr_pkg::BYTE_W-1:0] extra_byte_q;
  logic                       eom_q;

  // output register
  logic                       out_valid_q;
  logic [fwr_pkg::BYTE_W-1:0] out_char_q;
  logic                       out_last_msg_q, out_last_burst_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_word_q  <= '0;
      search_len_q   <= '0;
      replace_word_q <= '0;
      replace_len_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (fwr_pkg::cfg_idx_e'(cfg_index_i))
        fwr_pkg::CFG_SEARCH_WORD:    search_word_q  <= cfg_data_i;
        fwr_pkg::CFG_SEARCH_LENGTH:  search_len_q   <= cfg_data_i[fwr_pkg::LEN_W-1:0];
        fwr_pkg::CFG_REPLACE_WORD:   replace_word_q <= cfg_data_i;
        fwr_pkg::CFG_REPLACE_LENGTH: replace_len_q  <= cfg_data_i[fwr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode of the incoming byte against the current word state
  logic                       is_space, at_full, buffer_it, match;
  logic [fwr_pkg::LEN_W-1:0]  len_eff, repl_len_c;
  logic                       eq_eff;
  logic [fwr_pkg::BYTE_W-1:0] search_byte;

  always_comb begin
    is_space    = (char_i == fwr_pkg::SPACE_CHAR);
    at_full     = (len_q >= MaxLen);
    buffer_it   = !is_space && !ovf_q && !at_full;
    search_byte = search_word_q[{len_q[2:0], 3'b000} +: fwr_pkg::BYTE_W];
    len_eff     = buffer_it ? fwr_pkg::LEN_W'(len_q + 4'd1) : len_q;
    eq_eff      = buffer_it ? (eq_q && (char_i == search_byte)) : eq_q;
    match       = !ovf_q && !rdone_q && (search_len_q <= MaxLen)
                  && (len_eff == search_len_q) && eq_eff;
    repl_len_c  = (replace_len_q > fwr_pkg::WORD_BYTES) ? fwr_pkg::WORD_BYTES
                                                         : replace_len_q;
  end

  // Burst plan and state update for an accepted byte
  always_comb begin
    src_repl_d = 1'b0;
    cnt_d      = '0;
    extra_d    = 1'b0;
    len_d      = len_q;
    ovf_d      = ovf_q;
    rdone_d    = rdone_q;
    eq_d       = eq_eff;
    if (is_space) begin
      // word ends: word or replacement, then the space
      src_repl_d = match;
      cnt_d      = match ? repl_len_c : len_q;
      extra_d    = 1'b1;
      len_d      = '0;
      ovf_d      = 1'b0;
      eq_d       = 1'b1;
      if (match) begin
        rdone_d = 1'b1;
      end
    end else if (ovf_q) begin
      // overflowed word passes straight through
      extra_d = 1'b1;
    end else if (at_full) begin
      // overflow: flush buffer, then this byte
      cnt_d   = len_q;
      extra_d = 1'b1;
      len_d   = '0;
      ovf_d   = 1'b1;
      eq_d    = 1'b1;
    end else begin
      len_d = len_eff;
      if (eom_i) begin
        src_repl_d = match;
        cnt_d      = match ? repl_len_c : len_eff;
      end
    end
    if (eom_i) begin
      len_d   = '0;
      ovf_d   = 1'b0;
      rdone_d = 1'b0;
      eq_d    = 1'b1;
    end
    total_d = fwr_pkg::LEN_W'(cnt_d + fwr_pkg::LEN_W'(extra_d));
  end

  // Word state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      ovf_q   <= 1'b0;
      rdone_q <= 1'b0;
      eq_q    <= 1'b1;
    end else if (cmd_i.accept) begin
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      rdone_q <= rdone_d;
      eq_q    <= eq_d;
    end
  end

  // Word buffer, written at the current length
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && buffer_it) begin
      word_buf_q[len_q[IdxW-1:0]] <= char_i;
    end
  end

  // Burst registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.accept) begin
      idx_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= fwr_pkg::LEN_W'(idx_q + 4'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      src_repl_q   <= src_repl_d;
      cnt_q        <= cnt_d;
      total_q      <= total_d;
      extra_byte_q <= char_i;
      eom_q        <= eom_i;
    end
  end

  // Next burst byte
  logic [fwr_pkg::BYTE_W-1:0] emit_byte;
  logic                       emit_last;
  always_comb begin
    if (idx_q < cnt_q) begin
      emit_byte = src_repl_q ? replace_word_q[{idx_q[2:0], 3'b000} +: fwr_pkg::BYTE_W]
                             : word_buf_q[idx_q[IdxW-1:0]];
    end else begin
      emit_byte = extra_byte_q;
    end
    emit_last = (fwr_pkg::LEN_W'(idx_q + 4'd1) == total_q);
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_char_q       <= emit_byte;
      out_last_burst_q <= emit_last;
      out_last_msg_q   <= emit_last && eom_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_char_o       = out_char_q;
  assign out_last_msg_o   = out_last_msg_q;
  assign out_last_burst_o = out_last_burst_q;

  assign sts_o.burst_nonempty = (total_d != '0);
  assign sts_o.emit_last      = emit_last;
  assign sts_o.out_busy       = out_valid_q && !out_ready_i;

  // A load never runs past the planned burst
  a_idx_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (idx_q < total_q))
    else $error("burst index beyond burst length");

  // Buffered length never exceeds the word limit
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= MaxLen)
    else $error("word length beyond limit");

endmodule
`default_nettype wire

[sv/first_word_replace_stream.sv]
// Top level: whole-word search and replace of the first match in each message.
// Bursts: a byte that ends a word is accepted while idle; its burst of n bytes
//   (up to nine) is loaded into the output register one byte per cycle unless
//   the output stalls. A byte that only joins the word buffer leaves the input
//   ready; a byte that yields output blocks input until its burst is loaded.
// Reset: rst_ni clears the configuration to zero and the word state; the word
//   buffer contents are not reset.
`default_nettype none
module first_word_replace_stream #(
  parameter int unsigned MAX_WORD = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [fwr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [fwr_pkg::WORD_W-1:0]    cfg_data_i,
  // input stream
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [7:0]                    s_axis_tdata_i,  // [7:0] char_in
  input  wire logic                          s_axis_tlast_i,  // end_of_message
  // output stream
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [7:0]                         m_axis_tdata_o,  // [7:0] char_out
  output logic                               m_axis_tlast_o,  // last_of_message
  output logic                               m_axis_tuser_o   // [0] last_of_burst
);

  fwr_pkg::ctrl_cmd_t  cmd;
  fwr_pkg::dpath_sts_t sts;

  assign cfg_ready_o = 1'b1;

  fwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fwr_dpath #(
    .MAX_WORD (MAX_WORD)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .char_i           (s_axis_tdata_i),
    .eom_i            (s_axis_tlast_i),
    .out_ready_i      (m_axis_tready_i),
    .out_valid_o      (m_axis_tvalid_o),
    .out_char_o       (m_axis_tdata_o),
    .out_last_msg_o   (m_axis_tlast_o),
    .out_last_burst_o (m_axis_tuser_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

  // Input transfer and burst load never share a cycle
  a_no_accept_and_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.accept && cmd.load))
    else $error("input accepted while a burst is loading");

  // A byte that starts a burst blocks the input on the next cycle
  a_burst_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && sts.burst_nonempty) |=> !s_axis_tready_o)
    else $error("input ready during a burst");

  // End of message is only flagged on the final byte of a burst
  a_last_msg_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> m_axis_tuser_o)
    else $error("message end not on burst end");

endmodule
`default_nettype wire
